/* rtl/core/srsg_pkg.sv */
// Package for the stepper ramp step generator.
// Holds word types, codes, fixed widths and the controller/datapath link types.
// No dependencies.
package srsg_pkg;

  localparam int STEP_COUNT_BITS  = 22;
  localparam int MIN_INTERVAL_US  = 60;
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int SPEED_FRAC_BITS  = 16;

  localparam int RATE_W  = 15;
  localparam int ACCEL_W = 20;
  localparam int RUNMS_W = 22;
  localparam int INTV_W  = 20;
  localparam int SPEED_W = 32;
  localparam int ELAP_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam int DVD_W = 56;
  localparam int DSR_W = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MS   = 3'd5;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_CAPTURE = 4'd1;
  localparam logic [3:0] OP_FAULT   = 4'd2;
  localparam logic [3:0] OP_TICK    = 4'd3;
  localparam logic [3:0] OP_MUL     = 4'd4;
  localparam logic [3:0] OP_SPEED   = 4'd5;
  localparam logic [3:0] OP_INTV    = 4'd6;
  localparam logic [3:0] OP_ENDCHK  = 4'd7;
  localparam logic [3:0] OP_BEGIN   = 4'd8;
  localparam logic [3:0] OP_SINTV   = 4'd9;
  localparam logic [3:0] OP_DECEL   = 4'd10;
  localparam logic [3:0] OP_END     = 4'd11;
  localparam logic [3:0] OP_RESULT  = 4'd12;

  localparam logic [1:0] DIV_DELTA = 2'd0;
  localparam logic [1:0] DIV_INTV  = 2'd1;
  localparam logic [1:0] DIV_START = 2'd2;
  localparam logic [1:0] DIV_DECEL = 2'd3;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [STEP_COUNT_BITS-1:0] step_count;
    logic                       forward;
  } in_word_t;

  typedef struct packed {
    logic                       step_pulse;
    logic                       dir_level;
    logic                       driver_enable;
    logic                       busy_res;
    logic                       start_accepted;
    logic                       fault_timeout;
    logic [STEP_COUNT_BITS-1:0] steps_done;
    logic [STEP_COUNT_BITS-1:0] steps_left;
  } out_word_t;

  typedef struct packed {
    logic [3:0] op;
    logic       div_start;
    logic [1:0] div_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       moving;
    logic       n_zero;
    logic       timeout;
    logic       stepped;
    logic       accel_zero;
    logic       div_done;
    logic       out_busy;
  } sts_t;

endpackage

/* rtl/core/srsg_in_if.sv */
// Input channel of the stepper ramp step generator.
// Depends on srsg_pkg.
interface srsg_in_if;
  logic                valid;
  logic                ready;
  srsg_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/srsg_out_if.sv */
// Result channel of the stepper ramp step generator.
// Depends on srsg_pkg.
interface srsg_out_if;
  logic                valid;
  logic                ready;
  srsg_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/srsg_cfg_if.sv */
// Configuration write channel of the stepper ramp step generator.
// Depends on srsg_pkg.
interface srsg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [srsg_pkg::CFG_IDX_W-1:0]      index;
  logic [srsg_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/srsg_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on srsg_pkg.
module srsg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [srsg_pkg::DVD_W-1:0]  dividend,
  input  logic [srsg_pkg::DSR_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [srsg_pkg::DVD_W-1:0]  quotient
);
  import srsg_pkg::*;

  logic [DVD_W-1:0]     dvd;
  logic [DSR_W-1:0]     dsr;
  logic [DSR_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DSR_W:0]       shifted;
  logic [DSR_W+1:0]     trial;

  assign shifted  = {rem, dvd[DVD_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DSR_W+1]) begin
        rem <= trial[DSR_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DSR_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/srsg_ctrl.sv */
// Sequencing state machine of the stepper ramp step generator.
// Depends on srsg_pkg; drives srsg_dp through cmd_t and reads sts_t.
module srsg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  srsg_pkg::sts_t sts,
  output srsg_pkg::cmd_t cmd
);
  import srsg_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_TICKCHK = 4'd2;
  localparam logic [3:0] S_DELTA   = 4'd3;
  localparam logic [3:0] S_DWAIT   = 4'd4;
  localparam logic [3:0] S_SPEED   = 4'd5;
  localparam logic [3:0] S_IDIV    = 4'd6;
  localparam logic [3:0] S_INTV    = 4'd7;
  localparam logic [3:0] S_ENDCHK  = 4'd8;
  localparam logic [3:0] S_SDIV    = 4'd9;
  localparam logic [3:0] S_SINTV   = 4'd10;
  localparam logic [3:0] S_ADIV    = 4'd11;
  localparam logic [3:0] S_SDECEL  = 4'd12;
  localparam logic [3:0] S_RESULT  = 4'd13;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DIV_DELTA;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESULT;
        case (sts.kind)
          KIND_TICK: begin
            if (sts.moving && sts.timeout) begin
              cmd.op = OP_FAULT;
            end else if (sts.moving) begin
              cmd.op     = OP_TICK;
              state_next = S_TICKCHK;
            end
          end
          KIND_START: begin
            if (!sts.moving && !sts.n_zero) begin
              cmd.op     = OP_BEGIN;
              state_next = S_SDIV;
            end
          end
          KIND_STOP: cmd.op = OP_END;
          default: state_next = S_RESULT;
        endcase
      end
      S_TICKCHK: begin
        if (sts.stepped) begin
          cmd.op     = OP_MUL;
          state_next = S_DELTA;
        end else begin
          state_next = S_ENDCHK;
        end
      end
      S_DELTA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DELTA;
        ret_next      = S_SPEED;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) state_next = ret;
      end
      S_SPEED: begin
        cmd.op     = OP_SPEED;
        state_next = S_IDIV;
      end
      S_IDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_INTV;
        ret_next      = S_INTV;
        state_next    = S_DWAIT;
      end
      S_INTV: begin
        cmd.op     = OP_INTV;
        state_next = S_ENDCHK;
      end
      S_ENDCHK: begin
        cmd.op     = OP_ENDCHK;
        state_next = S_RESULT;
      end
      S_SDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_START;
        ret_next      = S_SINTV;
        state_next    = S_DWAIT;
      end
      S_SINTV: begin
        cmd.op     = OP_SINTV;
        state_next = sts.accel_zero ? S_RESULT : S_ADIV;
      end
      S_ADIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DECEL;
        ret_next      = S_SDECEL;
        state_next    = S_DWAIT;
      end
      S_SDECEL: begin
        cmd.op     = OP_DECEL;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

/* rtl/core/srsg_dp.sv */
// Datapath of the stepper ramp step generator: registers, move state, ramp math.
// Depends on srsg_pkg and srsg_div; commanded by srsg_ctrl.
module srsg_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  srsg_pkg::cmd_t                cmd,
  output srsg_pkg::sts_t                sts,
  input  srsg_pkg::in_word_t            in_data,
  input  logic                          cfg_we,
  input  logic [srsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srsg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output srsg_pkg::out_word_t           out_data
);
  import srsg_pkg::*;

  localparam logic [DVD_W-1:0] TPS_Q = DVD_W'(TICKS_PER_SECOND) << SPEED_FRAC_BITS;
  localparam logic [9:0] TICKS_PER_MS = 10'(TICKS_PER_SECOND / 1000);

  localparam int RCP_S = 54;
  localparam int RCP_W = ACCEL_W + INTV_W + 51;
  localparam logic [71:0] RCP_NUM = 72'd1 << (SPEED_FRAC_BITS + RCP_S);
  localparam logic [50:0] RCP_K =
    51'((RCP_NUM + 72'(TICKS_PER_SECOND - 1)) / 72'(TICKS_PER_SECOND));

  logic [RATE_W-1:0]  max_rate, min_rate;
  logic [ACCEL_W-1:0] accel;
  logic               invert_dir, hold_enable;
  logic [RUNMS_W-1:0] max_run_ms;
  logic [ELAP_W-1:0]  limit;

  logic [1:0]                 kind;
  logic [STEP_COUNT_BITS-1:0] n_cap;
  logic                       fwd_cap;

  logic                       moving, fault_flag, drv_on, dir_out;
  logic [STEP_COUNT_BITS-1:0] left_count, done_count, decel_point;
  logic [SPEED_W-1:0]         speed_q16;
  logic [INTV_W-1:0]          interval_us, wait_us;
  logic [ELAP_W-1:0]          elapsed_us;
  logic                       step_flag, accepted;
  logic [2*RATE_W-1:0]        vmax2, vmin2;
  logic [ACCEL_W+INTV_W-1:0]  prod;

  logic [RATE_W-1:0]          r0;
  logic [STEP_COUNT_BITS-1:0] half;
  logic                       div_start, div_busy, div_done;
  logic [DVD_W-1:0]           div_dvd, quot;
  logic [DSR_W-1:0]           div_dsr;
  logic [DVD_W:0]             sp_down, sp_up, sp_clamp;
  logic [DVD_W:0]             lo, hi;
  logic [DVD_W-1:0]           q_min;
  logic [INTV_W-1:0]          q_sat, s_sat;
  logic [DVD_W-1:0]           ds;

  logic                       rcp_start, rcp_busy, rcp_done;
  logic [2:0]                 rcp_cnt;
  logic [19:0]                rcp_a;
  logic [16:0]                rcp_b;
  logic [36:0]                rcp_pp;
  logic [RCP_W-1:0]           rcp_term, rcp_acc;
  logic [DVD_W-1:0]           delta;

  assign r0   = (min_rate == '0) ? RATE_W'(1) : min_rate;
  assign half = n_cap >> 1;
  assign lo   = (DVD_W+1)'(r0) << SPEED_FRAC_BITS;
  assign hi   = (DVD_W+1)'(max_rate) << SPEED_FRAC_BITS;

  always_comb begin
    case (cmd.div_sel)
      DIV_INTV: begin
        div_dvd = TPS_Q;
        div_dsr = speed_q16;
      end
      DIV_START: begin
        div_dvd = DVD_W'(TICKS_PER_SECOND);
        div_dsr = DSR_W'(r0);
      end
      default: begin
        div_dvd = (vmax2 > vmin2) ? DVD_W'(vmax2 - vmin2) : '0;
        div_dsr = DSR_W'({accel, 1'b0});
      end
    endcase
  end

  assign div_start = cmd.div_start && (cmd.div_sel != DIV_DELTA);
  assign rcp_start = cmd.div_start && (cmd.div_sel == DIV_DELTA);

  srsg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // The speed change accel * interval * 2^16 / 10^6 is a multiply by a scaled
  // reciprocal, built from six 20 by 17 bit partial products.
  // It is exact for every 40-bit product.
  always_comb begin
    rcp_a = rcp_cnt[0] ? prod[39:20] : prod[19:0];
    case (rcp_cnt[2:1])
      2'd0:    rcp_b = RCP_K[16:0];
      2'd1:    rcp_b = RCP_K[33:17];
      default: rcp_b = RCP_K[50:34];
    endcase
    rcp_pp = 37'(rcp_a) * 37'(rcp_b);
    case (rcp_cnt)
      3'd0:    rcp_term = RCP_W'(rcp_pp);
      3'd1:    rcp_term = RCP_W'(rcp_pp) << 20;
      3'd2:    rcp_term = RCP_W'(rcp_pp) << 17;
      3'd3:    rcp_term = RCP_W'(rcp_pp) << 37;
      3'd4:    rcp_term = RCP_W'(rcp_pp) << 34;
      default: rcp_term = RCP_W'(rcp_pp) << 54;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcp_busy <= 1'b0;
      rcp_done <= 1'b0;
      rcp_cnt  <= '0;
    end else begin
      rcp_done <= 1'b0;
      if (rcp_start) begin
        rcp_busy <= 1'b1;
        rcp_cnt  <= '0;
      end else if (rcp_busy) begin
        rcp_cnt <= rcp_cnt + 1'b1;
        if (rcp_cnt == 3'd5) begin
          rcp_busy <= 1'b0;
          rcp_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rcp_start) rcp_acc <= '0;
    else if (rcp_busy) rcp_acc <= rcp_acc + rcp_term;
  end

  assign delta = DVD_W'(rcp_acc[RCP_W-1:RCP_S]);

  // Ramp step: accelerate toward the maximum rate, and decelerate once the remaining steps reach the braking point.
  always_comb begin
    sp_down = ((DVD_W+1)'(speed_q16) > {1'b0, delta}) ?
              (DVD_W+1)'(speed_q16) - {1'b0, delta} : '0;
    if (sp_down < lo) sp_down = lo;
    sp_up = (DVD_W+1)'(speed_q16) + {1'b0, delta};
    if (sp_up > hi) sp_up = hi;
    sp_clamp = (left_count <= decel_point) ? sp_down : sp_up;
    if (sp_clamp < lo) sp_clamp = lo;
    if (sp_clamp > (DVD_W+1)'({SPEED_W{1'b1}})) sp_clamp = (DVD_W+1)'({SPEED_W{1'b1}});
  end

  always_comb begin
    q_min = (quot < DVD_W'(MIN_INTERVAL_US)) ? DVD_W'(MIN_INTERVAL_US) : quot;
    q_sat = (q_min > DVD_W'({INTV_W{1'b1}})) ? {INTV_W{1'b1}} : q_min[INTV_W-1:0];
    s_sat = (quot > DVD_W'({INTV_W{1'b1}})) ? {INTV_W{1'b1}} : quot[INTV_W-1:0];
    ds = (quot == '0) ? DVD_W'(1) : quot;
    if (ds > DVD_W'(half)) ds = DVD_W'(half);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate    <= RATE_W'(2000);
      min_rate    <= RATE_W'(100);
      accel       <= ACCEL_W'(4000);
      invert_dir  <= 1'b0;
      hold_enable <= 1'b0;
      max_run_ms  <= RUNMS_W'(60000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RATE: max_rate    <= cfg_data[RATE_W-1:0];
        REG_MIN_RATE: min_rate    <= cfg_data[RATE_W-1:0];
        REG_ACCEL:    accel       <= cfg_data[ACCEL_W-1:0];
        REG_INVERT:   invert_dir  <= cfg_data[0];
        REG_HOLD:     hold_enable <= cfg_data[0];
        REG_RUN_MS:   max_run_ms  <= cfg_data[RUNMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit <= ELAP_W'(max_run_ms) * ELAP_W'(TICKS_PER_MS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moving      <= 1'b0;
      fault_flag  <= 1'b0;
      drv_on      <= 1'b0;
      dir_out     <= 1'b0;
      left_count  <= '0;
      done_count  <= '0;
      decel_point <= '0;
      speed_q16   <= '0;
      interval_us <= '0;
      wait_us     <= '0;
      elapsed_us  <= '0;
      step_flag   <= 1'b0;
      accepted    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.op == OP_RESULT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_CAPTURE: begin
          step_flag <= 1'b0;
          accepted  <= 1'b0;
        end
        OP_FAULT: begin
          fault_flag <= 1'b1;
          moving     <= 1'b0;
          left_count <= '0;
          if (!hold_enable) drv_on <= 1'b0;
        end
        OP_TICK: begin
          if (elapsed_us != {ELAP_W{1'b1}}) elapsed_us <= elapsed_us + 1'b1;
          if (left_count != '0) begin
            if (wait_us == '0) begin
              step_flag  <= 1'b1;
              left_count <= left_count - 1'b1;
              done_count <= done_count + 1'b1;
            end else begin
              wait_us <= wait_us - 1'b1;
            end
          end
        end
        OP_SPEED: speed_q16 <= sp_clamp[SPEED_W-1:0];
        OP_INTV: begin
          interval_us <= q_sat;
          wait_us     <= q_sat - 1'b1;
        end
        OP_END, OP_ENDCHK: begin
          if (cmd.op == OP_END || left_count == '0) begin
            moving     <= 1'b0;
            left_count <= '0;
            if (!hold_enable) drv_on <= 1'b0;
          end
        end
        OP_BEGIN: begin
          accepted   <= 1'b1;
          dir_out    <= fwd_cap ^ invert_dir;
          drv_on     <= 1'b1;
          left_count <= n_cap;
          done_count <= '0;
          speed_q16  <= SPEED_W'(r0) << SPEED_FRAC_BITS;
          wait_us    <= '0;
          elapsed_us <= '0;
          moving     <= 1'b1;
        end
        OP_SINTV: begin
          interval_us <= s_sat;
          if (accel == '0) decel_point <= half;
        end
        OP_DECEL: decel_point <= ds[STEP_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      kind    <= in_data.kind;
      n_cap   <= in_data.step_count;
      fwd_cap <= in_data.forward;
    end
    if (cmd.op == OP_BEGIN) begin
      vmax2 <= (2*RATE_W)'(max_rate) * (2*RATE_W)'(max_rate);
      vmin2 <= (2*RATE_W)'(r0) * (2*RATE_W)'(r0);
    end
    if (cmd.op == OP_MUL) prod <= (ACCEL_W+INTV_W)'(accel) * (ACCEL_W+INTV_W)'(interval_us);
    if (cmd.op == OP_RESULT) begin
      out_data.step_pulse     <= step_flag;
      out_data.dir_level      <= dir_out;
      out_data.driver_enable  <= drv_on;
      out_data.busy_res       <= moving;
      out_data.start_accepted <= accepted;
      out_data.fault_timeout  <= fault_flag;
      out_data.steps_done     <= done_count;
      out_data.steps_left     <= left_count;
    end
  end

  assign sts.kind       = kind;
  assign sts.moving     = moving;
  assign sts.n_zero     = (n_cap == '0);
  assign sts.timeout    = (elapsed_us > limit);
  assign sts.stepped    = step_flag;
  assign sts.accel_zero = (accel == '0);
  assign sts.div_done   = div_done || rcp_done;
  assign sts.out_busy   = out_valid && !out_ready;

  a_drv_while_moving: assert property (@(posedge clk) disable iff (rst)
    moving |-> drv_on) else $error("driver off during a move");
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag) else $error("fault flag cleared");
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_rcp_idle_start: assert property (@(posedge clk) disable iff (rst)
    rcp_start |-> !rcp_busy) else $error("speed change restarted while busy");

endmodule

/* rtl/core/stepper_ramp_step_generator.sv */
// Stepper ramp step generator: each word is a microsecond tick, a move start
// or a stop, and gives one result word with the step pulse and move status.
// A stop, an unknown kind, a rejected start, an idle tick or a fault tick goes
// straight to its result; a stepping tick runs a reciprocal multiply for the
// speed change and one pass of the shared divider for the new interval, and an
// accepted start runs two divider passes, or one with zero acceleration. One
// word is processed at a time; a new result waits while the previous one has
// not been taken. Configuration writes are always accepted and must be done
// while no word is in flight.
module stepper_ramp_step_generator (
  input logic       clk,
  input logic       rst,
  srsg_in_if.sink   cmd,
  srsg_out_if.source res,
  srsg_cfg_if.sink  cfg
);
  import srsg_pkg::*;

  cmd_t ctl_cmd;
  sts_t dp_sts;

  assign cfg.ready = 1'b1;

  srsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  srsg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .sts       (dp_sts),
    .in_data   (cmd.data),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.data)
  );

endmodule

/* tb/srsg_checker.sv */
// Checker for the stepper ramp step generator: watches the command, result and
// configuration channels, predicts each result word and compares it.
// Depends on srsg_pkg and the channel interfaces.
module srsg_checker (
  input  logic clk,
  input  logic rst,
  srsg_in_if   cmd_mon,
  srsg_out_if  res_mon,
  srsg_cfg_if  cfg_mon,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import srsg_pkg::*;

  localparam logic [63:0] TPS = 64'(TICKS_PER_SECOND);
  localparam logic [63:0] INTV_SAT = 64'd1048575;

  logic [14:0] max_rate, min_rate;
  logic [19:0] accel;
  logic        invert, hold;
  logic [21:0] run_ms;

  logic        moving, fault, drv_on, dir_lvl;
  logic [21:0] left_cnt, done_cnt, decel_pt;
  logic [31:0] speed, intv, wait_cnt, elapsed;

  out_word_t   expected_words[$];

  assign pending = expected_words.size();

  function automatic logic [63:0] floor_rate();
    return (min_rate == 0) ? 64'd1 : 64'(min_rate);
  endfunction

  function automatic void finish_move();
    moving   = 1'b0;
    left_cnt = '0;
    if (!hold) drv_on = 1'b0;
  endfunction

  function automatic void ramp_speed();
    logic [63:0] lo, hi, sp, delta, q;
    lo    = floor_rate() << SPEED_FRAC_BITS;
    hi    = 64'(max_rate) << SPEED_FRAC_BITS;
    sp    = 64'(speed);
    delta = ((64'(accel) * 64'(intv)) << SPEED_FRAC_BITS) / TPS;
    if (left_cnt <= decel_pt) begin
      sp = (sp > delta) ? sp - delta : 64'd0;
      if (sp < lo) sp = lo;
    end else begin
      sp = sp + delta;
      if (sp > hi) sp = hi;
    end
    if (sp < lo) sp = lo;
    if (sp > 64'hFFFF_FFFF) sp = 64'hFFFF_FFFF;
    speed = sp[31:0];
    q = (TPS << SPEED_FRAC_BITS) / sp;
    if (q < 64'(MIN_INTERVAL_US)) q = 64'(MIN_INTERVAL_US);
    intv = (q > INTV_SAT) ? INTV_SAT[31:0] : q[31:0];
  endfunction

  function automatic logic start_move(logic [21:0] n, logic fwd);
    logic [63:0] r0, vmax2, vmin2, ds, half, iv;
    if (moving || n == 0) return 1'b0;
    r0    = floor_rate();
    vmax2 = 64'(max_rate) * 64'(max_rate);
    vmin2 = r0 * r0;
    half  = 64'(n >> 1);
    dir_lvl  = fwd ^ invert;
    drv_on   = 1'b1;
    left_cnt = n;
    done_cnt = '0;
    speed    = 32'(r0 << SPEED_FRAC_BITS);
    iv       = TPS / r0;
    intv     = (iv > INTV_SAT) ? INTV_SAT[31:0] : iv[31:0];
    wait_cnt = '0;
    elapsed  = '0;
    moving   = 1'b1;
    if (accel == 0) begin
      ds = half;
    end else begin
      ds = (vmax2 > vmin2) ? (vmax2 - vmin2) / (64'd2 * 64'(accel)) : 64'd0;
      if (ds < 1) ds = 1;
      if (ds > half) ds = half;
    end
    decel_pt = ds[21:0];
    return 1'b1;
  endfunction

  function automatic logic tick_move();
    logic [63:0] limit;
    logic        stepped;
    stepped = 1'b0;
    limit   = 64'(run_ms) * (TPS / 1000);
    if (!moving) return 1'b0;
    if (64'(elapsed) > limit) begin
      fault = 1'b1;
      finish_move();
      return 1'b0;
    end
    if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 32'd1;
    if (left_cnt > 0) begin
      if (wait_cnt == 0) begin
        stepped  = 1'b1;
        left_cnt = left_cnt - 22'd1;
        done_cnt = done_cnt + 22'd1;
        ramp_speed();
        wait_cnt = (intv > 0) ? intv - 32'd1 : 32'd0;
      end else begin
        wait_cnt = wait_cnt - 32'd1;
      end
    end
    if (left_cnt == 0) finish_move();
    return stepped;
  endfunction

  function automatic out_word_t predict_status(in_word_t w);
    out_word_t o;
    logic      pulse, accepted;
    pulse    = 1'b0;
    accepted = 1'b0;
    case (w.kind)
      KIND_TICK:  pulse = tick_move();
      KIND_START: accepted = start_move(w.step_count, w.forward);
      KIND_STOP:  finish_move();
      default: ;
    endcase
    o.step_pulse     = pulse;
    o.dir_level      = dir_lvl;
    o.driver_enable  = drv_on;
    o.busy_res       = moving;
    o.start_accepted = accepted;
    o.fault_timeout  = fault;
    o.steps_done     = done_cnt;
    o.steps_left     = left_cnt;
    return o;
  endfunction

  task automatic compare_field(string name, logic [21:0] exp_v, logic [21:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e, a;
    if (rst) begin
      max_rate = 15'd2000; min_rate = 15'd100; accel = 20'd4000;
      invert = 1'b0; hold = 1'b0; run_ms = 22'd60000;
      moving = 1'b0; fault = 1'b0; drv_on = 1'b0; dir_lvl = 1'b0;
      left_cnt = '0; done_cnt = '0; decel_pt = '0;
      speed = '0; intv = '0; wait_cnt = '0; elapsed = '0;
      errors = 0;
      expected_words.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_MAX_RATE: max_rate = cfg_mon.data[14:0];
          REG_MIN_RATE: min_rate = cfg_mon.data[14:0];
          REG_ACCEL:    accel    = cfg_mon.data[19:0];
          REG_INVERT:   invert   = cfg_mon.data[0];
          REG_HOLD:     hold     = cfg_mon.data[0];
          REG_RUN_MS:   run_ms   = cfg_mon.data[21:0];
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready)
        expected_words.push_back(predict_status(cmd_mon.data));
      if (res_mon.valid && res_mon.ready) begin
        a = res_mon.data;
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, actual %h", $time, a);
          errors++;
        end else begin
          e = expected_words.pop_front();
          compare_field("step_pulse", 22'(e.step_pulse), 22'(a.step_pulse));
          compare_field("dir_level", 22'(e.dir_level), 22'(a.dir_level));
          compare_field("driver_enable", 22'(e.driver_enable), 22'(a.driver_enable));
          compare_field("busy_res", 22'(e.busy_res), 22'(a.busy_res));
          compare_field("start_accepted", 22'(e.start_accepted), 22'(a.start_accepted));
          compare_field("fault_timeout", 22'(e.fault_timeout), 22'(a.fault_timeout));
          compare_field("steps_done", e.steps_done, a.steps_done);
          compare_field("steps_left", e.steps_left, a.steps_left);
        end
      end
    end
  end

endmodule

/* tb/stepper_ramp_step_generator_tb.sv */
// Top of the stepper ramp step generator testbench: clock, reset, stimulus,
// configuration phases, receiver stalls and the verdict.
// Depends on srsg_pkg, the channel interfaces, srsg_checker and the block.
module stepper_ramp_step_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srsg_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   errors, pending;

  srsg_in_if  cmd ();
  srsg_out_if res ();
  srsg_cfg_if cfg ();

  stepper_ramp_step_generator i_dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res), .cfg(cfg));

  srsg_checker i_checker (
    .clk(clk), .rst(rst), .cmd_mon(cmd), .res_mon(res), .cfg_mon(cfg),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      res.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      res.ready <= 1'b0;
      hold_cnt <= 600;
      hold_done <= 1'b1;
    end else begin
      res.ready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_word(logic [1:0] kind, logic [21:0] n, logic fwd);
    in_word_t w;
    w.kind = kind;
    w.step_count = n;
    w.forward = fwd;
    if (!quiet && $urandom_range(99) < 23) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data <= w;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [21:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic wait_idle();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(int mx, int mn, int ac, bit inv, bit hld, int ms);
    wait_idle();
    write_reg(REG_MAX_RATE, 22'(mx));
    write_reg(REG_MIN_RATE, 22'(mn));
    write_reg(REG_ACCEL, 22'(ac));
    write_reg(REG_INVERT, 22'(inv));
    write_reg(REG_HOLD, 22'(hld));
    write_reg(REG_RUN_MS, 22'(ms));
    cfg.valid <= 1'b0;
  endtask

  function automatic int pick_value(int lo, int hi);
    int r;
    r = $urandom_range(3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  task automatic random_word();
    int          r;
    logic [21:0] n;
    r = $urandom_range(99);
    n = 22'($urandom);
    if (r < 8) begin
      r = $urandom_range(9);
      if (r < 7) n = 22'($urandom_range(1, 16));
      else if (r == 7) n = '0;
      send_word(KIND_START, n, 1'($urandom));
    end else if (r < 10) begin
      send_word(KIND_STOP, n, 1'($urandom));
    end else if (r < 12) begin
      send_word(KIND_UNUSED, n, 1'($urandom));
    end else begin
      send_word(KIND_TICK, n, 1'($urandom));
    end
  endtask

  initial begin
    cmd.valid <= 1'b0;
    cmd.data <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(KIND_START, 22'd0, 1'b1);
    send_word(KIND_STOP, 22'h3FFFFF, 1'b0);
    send_word(KIND_UNUSED, 22'h3FFFFF, 1'b1);
    send_word(KIND_TICK, 22'd0, 1'b0);
    send_word(KIND_START, 22'd1, 1'b1);
    send_word(KIND_START, 22'd5, 1'b0);
    send_word(KIND_TICK, 22'd0, 1'b0);
    send_word(KIND_START, 22'h3FFFFF, 1'b0);
    repeat (3) send_word(KIND_TICK, 22'd0, 1'b0);
    send_word(KIND_STOP, 22'd0, 1'b0);
    set_config(16666, 16666, 1000000, 1'b1, 1'b1, 3600000);
    send_word(KIND_START, 22'd3, 1'b1);
    repeat (8) send_word(KIND_TICK, 22'h2AAAAA, 1'b1);
    send_word(KIND_STOP, 22'd0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(16666, 16666, 1000000, 1'b0, 1'b0, 3600000);
        1: set_config(1, 1, 1, 1'b1, 1'b0, 1);
        2: set_config(16666, 16666, 1, 1'b0, 1'b1, 3600000);
        default: set_config(pick_value(1, 16666), $urandom_range(4000, 16666),
                            pick_value(1, 1000000), 1'($urandom), 1'($urandom),
                            pick_value(1, 3600000));
      endcase
      for (int i = 0; i < 52; i++) begin
        if (p == 2 && i == 10) hold_req <= 1'b1;
        if (p == 4) quiet <= (i < 40);
        random_word();
      end
      quiet <= 1'b0;
    end

    set_config(1, 1, 1, 1'b0, 1'b1, 1);
    send_word(KIND_START, 22'd5, 1'b1);
    repeat (1010) send_word(KIND_TICK, 22'($urandom), 1'($urandom));
    send_word(KIND_START, 22'd2, 1'b0);

    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/srsg_pkg.sv
rtl/core/srsg_in_if.sv
rtl/core/srsg_out_if.sv
rtl/core/srsg_cfg_if.sv
rtl/core/srsg_div.sv
rtl/core/srsg_ctrl.sv
rtl/core/srsg_dp.sv
rtl/core/stepper_ramp_step_generator.sv
tb/srsg_checker.sv
tb/stepper_ramp_step_generator_tb.sv
